>>> rtl/cwrs_pkg.sv
`default_nettype none

package cwrs_pkg;

  localparam int MAX_SIDE_DEF  = 64;
  localparam int ELEM_BITS_DEF = 32;

  localparam int SUM_W    = 44;
  localparam int ELEM_W   = 32;
  localparam int COORD_W  = 6;
  localparam int SIDE_W   = 7;

  // in_tdata: element_value, centre_row, centre_col, half_height, half_width
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CORNER_BR = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BL = 2'd2,
    CORNER_TL = 2'd3
  } corner_t;

  typedef struct packed {
    logic    ld_start;
    logic    ld_write;
    logic    q_start;
    logic    q_rd;
    corner_t corner;
    logic    out_load;
  } cwrs_cmd_t;

endpackage

`default_nettype wire

>>> rtl/clamped_window_rect_sum.sv
`default_nettype none

// Rectangle sums over a square signed matrix. Load items (tuser = 0) stream
// the matrix in row-major order and are folded into a summed-area table as
// they arrive; query items (tuser = 1) return the sum over the window around
// a centre, clamped to the matrix edges, modulo 2^44. cfg_data sets the side
// length (0 acts as 1, values above MAX_SIDE act as MAX_SIDE); the user must
// write it only while the block is idle, and the block does not enforce this.
// The table sits in one single-port memory with one access a cycle: a load
// reads the entry above, then writes; a query is accepted, reads the four
// corners, accumulates, then loads the output register, waiting while that
// register stays full. Loads produce no result. The table is not cleared;
// queries must only touch entries loaded since reset.
module clamped_window_rect_sum #(
  parameter int MAX_SIDE     = cwrs_pkg::MAX_SIDE_DEF,
  parameter int ELEMENT_BITS = cwrs_pkg::ELEM_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [cwrs_pkg::SIDE_W-1:0]         cfg_data,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // element_value[31:0], centre_row[37:32], centre_col[43:38],
  // half_height[49:44], half_width[55:50]
  input  wire logic [cwrs_pkg::IN_TDATA_W-1:0]     in_tdata,
  // op[0]
  input  wire logic                                in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // rect_sum[43:0], zero fill [47:44]
  output logic [cwrs_pkg::OUT_TDATA_W-1:0]         out_tdata
);
  import cwrs_pkg::*;

  cwrs_cmd_t               cmd;
  logic signed [SUM_W-1:0] rect_sum;

  assign cfg_ready = 1'b1;

  cwrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .cmd       (cmd)
  );

  cwrs_dp #(
    .MAX_SIDE     (MAX_SIDE),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_data      (cfg_data),
    .element_value (in_tdata[31:0]),
    .centre_row    (in_tdata[37:32]),
    .centre_col    (in_tdata[43:38]),
    .half_height   (in_tdata[49:44]),
    .half_width    (in_tdata[55:50]),
    .rect_sum      (rect_sum)
  );

  assign out_tdata = {{(OUT_TDATA_W-SUM_W){1'b0}}, rect_sum};

endmodule

`default_nettype wire

>>> rtl/cwrs_ctrl.sv
`default_nettype none

module cwrs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_op,
  output logic                    in_ready,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output cwrs_pkg::cwrs_cmd_t     cmd
);
  import cwrs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_WR,
    S_Q_RD,
    S_Q_ACC,
    S_Q_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.corner    = corner_t'(cnt_r);
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_QUERY) begin
            cmd.q_start = 1'b1;
            cnt_nxt     = 2'd0;
            state_nxt   = S_Q_RD;
          end else begin
            cmd.ld_start = 1'b1;
            state_nxt    = S_LD_WR;
          end
        end
      end
      S_LD_WR: begin
        cmd.ld_write = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_Q_RD: begin
        cmd.q_rd = 1'b1;
        cnt_nxt  = cnt_r + 2'd1;
        if (corner_t'(cnt_r) == CORNER_TL) state_nxt = S_Q_ACC;
      end
      S_Q_ACC: begin
        state_nxt = S_Q_OUT;
      end
      S_Q_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r & ~out_ready;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/cwrs_dp.sv
`default_nettype none

module cwrs_dp #(
  parameter int MAX_SIDE     = cwrs_pkg::MAX_SIDE_DEF,
  parameter int ELEMENT_BITS = cwrs_pkg::ELEM_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire cwrs_pkg::cwrs_cmd_t                  cmd,
  input  wire logic                                 cfg_we,
  input  wire logic [cwrs_pkg::SIDE_W-1:0]          cfg_data,
  input  wire logic signed [cwrs_pkg::ELEM_W-1:0]   element_value,
  input  wire logic [cwrs_pkg::COORD_W-1:0]         centre_row,
  input  wire logic [cwrs_pkg::COORD_W-1:0]         centre_col,
  input  wire logic [cwrs_pkg::COORD_W-1:0]         half_height,
  input  wire logic [cwrs_pkg::COORD_W-1:0]         half_width,
  output logic signed [cwrs_pkg::SUM_W-1:0]         rect_sum
);
  import cwrs_pkg::*;

  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CW     = (IDX_W > SIDE_W) ? SIDE_W : IDX_W;
  localparam logic [SIDE_W-1:0] SIDE_RST =
    (MAX_SIDE < 64) ? SIDE_W'(MAX_SIDE) : SIDE_W'(64);

  logic [SUM_W-1:0]  mem_r [DEPTH];
  logic [SUM_W-1:0]  rdata_r;
  logic [ADDR_W-1:0] addr;
  logic              mem_re;

  logic [SIDE_W-1:0] side_r;
  logic [CW-1:0]     row_r, col_r;
  logic [SUM_W-1:0]  rs_r;
  logic              above_ok_r;

  logic [CW-1:0]     row_a_r, row_b_r, col_a_r, col_b_r;
  logic              ne_r, tp_r, lp_r;
  logic              pend_r;
  corner_t           pend_corner_r;
  logic [SUM_W-1:0]  acc_r;
  logic [SUM_W-1:0]  out_r;

  logic signed [ELEMENT_BITS-1:0] elem_s;
  logic [SUM_W-1:0]  elem_ext;
  logic [SIDE_W-1:0] nm1;
  logic [COORD_W-1:0] top, left;
  logic [SIDE_W-1:0] bot_sum, right_sum, bot, right;
  logic              ne, tp, lp;
  logic [CW-1:0]     rd_row, rd_col;
  logic [SIDE_W:0]   col_inc, row_inc;

  function automatic logic [ADDR_W-1:0] to_addr(input logic [CW-1:0] r,
                                                input logic [CW-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_SIDE) + ADDR_W'(c);
  endfunction

  // query window clamp
  always_comb begin
    nm1       = side_r - SIDE_W'(1);
    top       = (centre_row > half_height) ? centre_row - half_height : '0;
    left      = (centre_col > half_width) ? centre_col - half_width : '0;
    bot_sum   = SIDE_W'(centre_row) + SIDE_W'(half_height);
    right_sum = SIDE_W'(centre_col) + SIDE_W'(half_width);
    bot       = (bot_sum > nm1) ? nm1 : bot_sum;
    right     = (right_sum > nm1) ? nm1 : right_sum;
    ne        = (SIDE_W'(top) <= bot) && (SIDE_W'(left) <= right);
    tp        = (top != '0);
    lp        = (left != '0);
  end

  always_comb begin
    elem_s   = element_value[ELEMENT_BITS-1:0];
    elem_ext = SUM_W'(elem_s);
    col_inc  = (SIDE_W+1)'(col_r) + (SIDE_W+1)'(1);
    row_inc  = (SIDE_W+1)'(row_r) + (SIDE_W+1)'(1);
  end

  always_comb begin
    rd_row = (cmd.corner == CORNER_TR || cmd.corner == CORNER_TL) ? row_b_r : row_a_r;
    rd_col = (cmd.corner == CORNER_BL || cmd.corner == CORNER_TL) ? col_b_r : col_a_r;
    mem_re = cmd.ld_start | cmd.q_rd;
    if (cmd.ld_start) begin
      addr = to_addr((row_r != '0) ? row_r - CW'(1) : '0, col_r);
    end else if (cmd.ld_write) begin
      addr = to_addr(row_r, col_r);
    end else begin
      addr = to_addr(rd_row, rd_col);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_write) begin
      mem_r[addr] <= rs_r + (above_ok_r ? rdata_r : '0);
    end else if (mem_re) begin
      rdata_r <= mem_r[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RST;
      row_r  <= '0;
      col_r  <= '0;
      rs_r   <= '0;
      pend_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_data == '0) side_r <= SIDE_W'(1);
        else if (cfg_data > MAX_SIDE) side_r <= SIDE_W'(MAX_SIDE);
        else side_r <= cfg_data;
      end
      if (cmd.ld_start) begin
        rs_r <= (col_r == '0) ? elem_ext : rs_r + elem_ext;
      end
      if (cmd.ld_write) begin
        if (col_inc >= (SIDE_W+1)'(side_r)) begin
          col_r <= '0;
          row_r <= (row_inc >= (SIDE_W+1)'(side_r)) ? '0 : row_r + CW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
      pend_r <= cmd.q_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_start) above_ok_r <= (row_r != '0);
    if (cmd.q_start) begin
      ne_r    <= ne;
      tp_r    <= tp;
      lp_r    <= lp;
      row_a_r <= CW'(bot);
      col_a_r <= CW'(right);
      row_b_r <= (ne && tp) ? CW'(top - COORD_W'(1)) : '0;
      col_b_r <= (ne && lp) ? CW'(left - COORD_W'(1)) : '0;
      acc_r   <= '0;
    end
    pend_corner_r <= cmd.corner;
    if (pend_r) begin
      case (pend_corner_r)
        CORNER_BR: if (ne_r) acc_r <= acc_r + rdata_r;
        CORNER_TR: if (ne_r && tp_r) acc_r <= acc_r - rdata_r;
        CORNER_BL: if (ne_r && lp_r) acc_r <= acc_r - rdata_r;
        CORNER_TL: if (ne_r && tp_r && lp_r) acc_r <= acc_r + rdata_r;
        default: ;
      endcase
    end
    if (cmd.out_load) out_r <= acc_r;
  end

  assign rect_sum = out_r;

endmodule

`default_nettype wire

>>> sim/testbench.sv
`default_nettype none

module testbench;
  import cwrs_pkg::*;

  localparam int SIDE_MAX  = MAX_SIDE_DEF;
  localparam int CELLS     = SIDE_MAX * SIDE_MAX;
  localparam int SETTLE    = 12;
  localparam int MAX_CYCLES = 600000;
  localparam int PHASES    = 12;

  typedef struct {
    bit                  cfg;
    logic                op;
    logic [ELEM_W-1:0]   elem;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  hh;
    logic [COORD_W-1:0]  hw;
    bit                  fixed;
    logic [SUM_W-1:0]    sum;
  } step_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [SIDE_W-1:0]      cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // element_value, centre_row, centre_col, half_height, half_width
  logic                   in_tuser;   // op
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // rect_sum, zero fill

  always #5 clk = ~clk;

  clamped_window_rect_sum i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // summed-area table shadow
  logic [SUM_W-1:0]  sat [CELLS];
  bit                filled [CELLS];
  int unsigned       ld_row = 0;
  int unsigned       ld_col = 0;
  logic [SUM_W-1:0]  row_acc = '0;
  logic [SIDE_W-1:0] side_reg = 7'd64;

  logic [SUM_W-1:0]  pending_sums [$];
  int                errors = 0;
  int                cycles = 0;
  int                send_pct = 0;
  int                stall_pct = 0;

  step_t script [22] = '{
    '{0, OP_LOAD,  32'h8000_0000,  0,  0,  0,  0, 0, 44'h0},
    '{0, OP_LOAD,  32'h7FFF_FFFF,  0,  0,  0,  0, 0, 44'h0},
    '{0, OP_LOAD,  32'hFFFF_FFFF,  0,  0,  0,  0, 0, 44'h0},
    '{0, OP_QUERY, 32'h0,          0,  0,  0,  0, 1, 44'hFFF_8000_0000},
    '{0, OP_QUERY, 32'h0,          0,  1,  0,  1, 1, 44'hFFF_FFFF_FFFE},
    // shrink mid-row: position beyond the new side wraps
    '{1, OP_LOAD,  32'd2,          0,  0,  0,  0, 0, 44'h0},
    '{0, OP_LOAD,  32'd5,          0,  0,  0,  0, 0, 44'h0},
    '{0, OP_LOAD,  32'h7FFF_FFFF,  0,  0,  0,  0, 0, 44'h0},
    '{0, OP_LOAD,  32'h7FFF_FFFF,  0,  0,  0,  0, 0, 44'h0},
    '{0, OP_QUERY, 32'h0,          1,  1, 63, 63, 0, 44'h0},
    '{0, OP_QUERY, 32'h0,         63, 63,  0,  0, 1, 44'h0},
    '{0, OP_QUERY, 32'h0,          0,  0,  0,  0, 1, 44'hFFF_8000_0000},
    '{0, OP_QUERY, 32'h0,          1,  0,  0,  0, 0, 44'h0},
    // side 0 acts as 1
    '{1, OP_LOAD,  32'd0,          0,  0,  0,  0, 0, 44'h0},
    '{0, OP_LOAD,  32'h1234_5678,  0,  0,  0,  0, 0, 44'h0},
    '{0, OP_QUERY, 32'h0,          0,  0, 63, 63, 1, 44'h000_1234_5678},
    '{0, OP_QUERY, 32'h0,          1,  0,  0,  0, 1, 44'h0},
    '{0, OP_LOAD,  32'hAAAA_5555,  0,  0,  0,  0, 0, 44'h0},
    '{0, OP_QUERY, 32'h0,          0, 63,  0,  0, 1, 44'h0},
    // oversize acts as the maximum
    '{1, OP_LOAD,  32'd127,        0,  0,  0,  0, 0, 44'h0},
    '{0, OP_LOAD,  32'h55AA_AA55,  0,  0,  0,  0, 0, 44'h0},
    '{0, OP_QUERY, 32'h0,          0,  0,  0,  1, 0, 44'h0}
  };

  logic [SIDE_W-1:0] phase_side [PHASES] = '{
    7'd5, 7'd1, 7'd8, 7'd0, 7'd3, 7'd16, 7'd127, 7'd2, 7'd7, 7'd64, 7'd4, 7'd65
  };

  function automatic int unsigned side_of(input logic [SIDE_W-1:0] v);
    if (v == 0) return 1;
    if (v > SIDE_MAX) return SIDE_MAX;
    return 32'(v);
  endfunction

  function automatic int unsigned cur_side();
    return side_of(side_reg);
  endfunction

  function automatic int unsigned sat_idx(input int unsigned r, input int unsigned c);
    return r * SIDE_MAX + c;
  endfunction

  function automatic void fold_element(input logic [ELEM_W-1:0] v);
    logic [SUM_W-1:0] ext;
    logic [SUM_W-1:0] above;
    int unsigned n;
    n = cur_side();
    ext = {{(SUM_W-ELEM_W){v[ELEM_W-1]}}, v};
    row_acc = (ld_col == 0) ? ext : row_acc + ext;
    above = (ld_row > 0) ? sat[sat_idx(ld_row - 1, ld_col)] : '0;
    sat[sat_idx(ld_row, ld_col)] = row_acc + above;
    filled[sat_idx(ld_row, ld_col)] = 1'b1;
    if (ld_col + 1 >= n) begin
      ld_col = 0;
      ld_row = (ld_row + 1 >= n) ? 0 : ld_row + 1;
    end else begin
      ld_col++;
    end
  endfunction

  // clamped window; returns 0 when it is empty
  function automatic bit window_bounds(input logic [COORD_W-1:0] r, c, hh, hw,
                                       output int unsigned top, bot, left, right);
    int unsigned n, ri, ci, hi, wi;
    n = cur_side();
    ri = 32'(r);
    ci = 32'(c);
    hi = 32'(hh);
    wi = 32'(hw);
    top   = (ri > hi) ? ri - hi : 0;
    left  = (ci > wi) ? ci - wi : 0;
    bot   = (ri + hi > n - 1) ? n - 1 : ri + hi;
    right = (ci + wi > n - 1) ? n - 1 : ci + wi;
    return (top <= bot) && (left <= right);
  endfunction

  function automatic logic [SUM_W-1:0] window_sum(input logic [COORD_W-1:0] r, c, hh, hw);
    int unsigned top, bot, left, right;
    logic [SUM_W-1:0] s;
    if (!window_bounds(r, c, hh, hw, top, bot, left, right)) return '0;
    s = sat[sat_idx(bot, right)];
    if (top > 0) s -= sat[sat_idx(top - 1, right)];
    if (left > 0) s -= sat[sat_idx(bot, left - 1)];
    if (top > 0 && left > 0) s += sat[sat_idx(top - 1, left - 1)];
    return s;
  endfunction

  // a query may only touch table entries loaded since reset
  function automatic bit query_ok(input logic [COORD_W-1:0] r, c, hh, hw);
    int unsigned top, bot, left, right;
    bit ok;
    if (!window_bounds(r, c, hh, hw, top, bot, left, right)) return 1'b1;
    ok = filled[sat_idx(bot, right)];
    if (top > 0) ok &= filled[sat_idx(top - 1, right)];
    if (left > 0) ok &= filled[sat_idx(bot, left - 1)];
    if (top > 0 && left > 0) ok &= filled[sat_idx(top - 1, left - 1)];
    return ok;
  endfunction

  function automatic logic [ELEM_W-1:0] pick_element();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_centre(input int unsigned n,
                                                     input int unsigned reach);
    case ($urandom_range(3))
      0: return COORD_W'($urandom_range(63));
      1: return COORD_W'($urandom_range(n - 1));
      2: return COORD_W'($urandom_range(reach));
      default: return COORD_W'($urandom_range(63, n - 1));
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_half();
    return $urandom_range(1) ? COORD_W'($urandom_range(3)) : COORD_W'($urandom_range(63));
  endfunction

  function automatic void report(input string what, input logic [OUT_TDATA_W-1:0] want,
                                 input logic [OUT_TDATA_W-1:0] got);
    errors++;
    if (errors <= 10) $display("%0t: %s: expected %h, got %h", $time, what, want, got);
  endfunction

  task automatic push_item(input logic op, input logic [ELEM_W-1:0] elem,
                           input logic [COORD_W-1:0] r, c, hh, hw,
                           input bit fixed, input logic [SUM_W-1:0] fixed_sum);
    int gap;
    logic [SUM_W-1:0] exp_sum;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {hw, hh, c, r, elem};
    do @(posedge clk); while (!in_tready);
    if (op == OP_LOAD) begin
      fold_element(elem);
    end else begin
      exp_sum = fixed ? fixed_sum : window_sum(r, c, hh, hw);
      pending_sums = {pending_sums, exp_sum};
    end
  endtask

  task automatic write_side(input logic [SIDE_W-1:0] v);
    in_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    side_reg = v;
  endtask

  task automatic run_phase(input logic [SIDE_W-1:0] new_side, input int mode,
                           input int count);
    logic [COORD_W-1:0] r, c, hh, hw;
    bit found;
    int n;
    // growing is only safe from the matrix origin
    if (side_of(new_side) > cur_side())
      while (ld_row != 0 || ld_col != 0)
        push_item(OP_LOAD, pick_element(), 0, 0, 0, 0, 0, '0);
    write_side(new_side);
    send_pct  = (mode == 1) ? 82 : (mode == 3) ? 9 : 0;
    stall_pct = (mode == 2) ? 82 : (mode == 3) ? 9 : 0;
    n = cur_side();
    for (int k = 0; k < count; k++) begin
      found = 1'b0;
      if ($urandom_range(99) < 45)
        for (int t = 0; t < 40 && !found; t++) begin
          r  = pick_centre(n, ld_row);
          c  = pick_centre(n, ld_row);
          hh = pick_half();
          hw = pick_half();
          found = query_ok(r, c, hh, hw);
        end
      if (found)
        push_item(OP_QUERY, $urandom(), r, c, hh, hw, 0, '0);
      else
        push_item(OP_LOAD, pick_element(), COORD_W'($urandom_range(63)),
                  COORD_W'($urandom_range(63)), COORD_W'($urandom_range(63)),
                  COORD_W'($urandom_range(63)), 0, '0);
    end
  endtask

  always @(posedge clk) begin
    logic [OUT_TDATA_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_sums.size() == 0) begin
        report("unexpected result", '0, out_tdata);
      end else begin
        want = {{(OUT_TDATA_W-SUM_W){1'b0}}, pending_sums.pop_front()};
        if (out_tdata !== want) report("rect_sum mismatch", want, out_tdata);
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tuser  <= OP_LOAD;
    in_tdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].cfg)
        write_side(script[i].elem[SIDE_W-1:0]);
      else
        push_item(script[i].op, script[i].elem, script[i].row, script[i].col,
                  script[i].hh, script[i].hw, script[i].fixed, script[i].sum);
    end

    for (int p = 0; p < PHASES; p++)
      run_phase(phase_side[p], p % 4, 100);

    in_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
